[rtl/core/fds_pkg.sv]
// Package for the directory search block: field widths, function codes,
// character packing constants and the controller/datapath handshake structs.
// No dependencies.
`default_nettype none

package fds_pkg;

    localparam int ENTRIES_DEFAULT = 2048;

    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 11;
    localparam int NAME_W  = 64;
    localparam int TYPE_W  = 4;
    localparam int HALF_W  = 24;
    localparam int ENTRY_W = 2 * HALF_W + TYPE_W;

    localparam logic [FUNC_W-1:0] FUNC_WRITE     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND_NAME = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND_TYPE = 2'd2;

    localparam logic [7:0] CHAR_BIAS  = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam int         CHAR_SHIFT = 6;

    localparam logic [TYPE_W-1:0] NO_TYPE = 4'hF;

    // controller -> datapath
    typedef struct packed {
        logic clear;     // clearing pass: write empty entry, advance pointer
        logic load;      // item accepted: capture and set up the scan
        logic scan;      // scan running
        logic res_load;  // capture the scan result
        logic out_load;  // move the result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic scan_done;
    } sts_t;

endpackage

`default_nettype wire

[rtl/core/fds_in_if.sv]
// Input channel of the directory search block: valid/ready plus item payload.
// Depends on fds_pkg.
`default_nettype none

interface fds_in_if;
    logic                            valid;
    logic                            ready;
    logic [fds_pkg::FUNC_W-1:0]      func;
    logic [fds_pkg::IDX_W-1:0]       index;
    logic [fds_pkg::NAME_W-1:0]      name_bytes;
    logic [fds_pkg::TYPE_W-1:0]      type_id;
    logic                            backward;
    logic [fds_pkg::HALF_W-1:0]      entry_first;
    logic [fds_pkg::HALF_W-1:0]      entry_second;

    modport source (
        output valid, func, index, name_bytes, type_id, backward, entry_first, entry_second,
        input  ready
    );
    modport sink (
        input  valid, func, index, name_bytes, type_id, backward, entry_first, entry_second,
        output ready
    );
    modport mon (
        input valid, ready, func, index, name_bytes, type_id, backward, entry_first,
              entry_second
    );
endinterface

`default_nettype wire

[rtl/core/fds_out_if.sv]
// Result channel of the directory search block: valid/ready plus result payload.
// Depends on fds_pkg.
`default_nettype none

interface fds_out_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [fds_pkg::IDX_W-1:0]  entry_index;

    modport source (output valid, found, entry_index, input ready);
    modport sink   (input valid, found, entry_index, output ready);
    modport mon    (input valid, ready, found, entry_index);
endinterface

`default_nettype wire

[rtl/core/fds_ctrl.sv]
// Controller of the directory search block: clearing pass, item accept,
// scan sequencing and output register handshake. Depends on fds_pkg.
`default_nettype none

module fds_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output fds_pkg::cmd_t      cmd,
    input  wire fds_pkg::sts_t sts
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/core/fds_datapath.sv]
// Datapath of the directory search block: entry memory, name packing,
// scan pointer and counter, compare stage and result/output registers.
// Depends on fds_pkg.
`default_nettype none

module fds_datapath #(
    parameter int ENTRIES = fds_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [fds_pkg::FUNC_W-1:0]     func,
    input  wire logic [fds_pkg::IDX_W-1:0]      index,
    input  wire logic [fds_pkg::NAME_W-1:0]     name_bytes,
    input  wire logic [fds_pkg::TYPE_W-1:0]     type_id,
    input  wire logic                           backward,
    input  wire logic [fds_pkg::HALF_W-1:0]     entry_first,
    input  wire logic [fds_pkg::HALF_W-1:0]     entry_second,
    input  wire fds_pkg::cmd_t                  cmd,
    output fds_pkg::sts_t                       sts,
    output logic                                found,
    output logic [fds_pkg::IDX_W-1:0]           entry_index
);

    localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam int XW   = ((CNTW > fds_pkg::IDX_W) ? CNTW : fds_pkg::IDX_W) + 1;
    localparam int HW   = fds_pkg::HALF_W;
    localparam int TW   = fds_pkg::TYPE_W;
    localparam int EW   = fds_pkg::ENTRY_W;

    localparam logic [AW-1:0]   LAST_POS  = AW'(ENTRIES - 1);
    localparam logic [XW-1:0]   ENTRIES_X = XW'(ENTRIES);
    localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(ENTRIES);

    typedef struct packed {
        logic          bad;
        logic [HW-1:0] first;
        logic [HW-1:0] second;
    } pack_t;

    // Pack up to eight name bytes, stopping at NUL or '.'; flag any code that
    // falls below the bias or spills past the 24-bit half.
    function automatic pack_t pack_name(input logic [fds_pkg::NAME_W-1:0] bytes);
        logic          live;
        logic [7:0]    ch;
        logic [7:0]    d;
        logic [HW-1:0] code;
        pack_t         r;
        live = 1'b1;
        r    = '0;
        for (int i = 0; i < 8; i++)
        begin
            ch = bytes[8*i +: 8];
            if (ch == fds_pkg::CHAR_NUL || ch == fds_pkg::CHAR_DOT)
                live = 1'b0;
            if (live)
            begin
                d    = ch - fds_pkg::CHAR_BIAS;
                code = HW'(d) << (fds_pkg::CHAR_SHIFT * (i % 4));
                if (ch < fds_pkg::CHAR_BIAS)
                    r.bad = 1'b1;
                if ((i % 4) == 3 && d[7:6] != 2'b00)
                    r.bad = 1'b1;
                if (i < 4)
                    r.first = r.first | code;
                else
                    r.second = r.second | code;
            end
        end
        return r;
    endfunction

    logic [EW-1:0] mem [ENTRIES];

    // control state
    logic [AW-1:0]   pos_reg, pos_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            pipe_vld_reg, pipe_vld_next;

    // payload
    logic [AW-1:0]   pipe_pos_reg;
    logic [EW-1:0]   rd_data_reg;
    logic            by_name_reg;
    logic            back_reg;
    logic [TW-1:0]   type_reg;
    logic [HW-1:0]   first_reg;
    logic [HW-1:0]   second_reg;
    logic            res_found_reg;
    logic [fds_pkg::IDX_W-1:0] res_index_reg;
    logic            out_found_reg;
    logic [fds_pkg::IDX_W-1:0] out_index_reg;

    pack_t         packed_name;
    logic [XW-1:0] idx_x;
    logic          idx_ok;
    logic          hit;
    logic          issue;
    logic [AW-1:0] step_pos;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [XW-1:0] hit_x;

    assign packed_name = pack_name(name_bytes);
    assign idx_x       = XW'(index);
    assign idx_ok      = (idx_x < ENTRIES_X);

    // compare stage on the registered read data
    always_comb
    begin
        if (by_name_reg)
            hit = pipe_vld_reg && (rd_data_reg == {first_reg, second_reg, type_reg});
        else
            hit = pipe_vld_reg && (rd_data_reg[TW-1:0] == type_reg);
    end

    assign issue = cmd.scan && (cnt_reg != '0) && !hit;

    always_comb
    begin
        if (back_reg)
            step_pos = (pos_reg == '0) ? LAST_POS : pos_reg - 1'b1;
        else
            step_pos = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    end

    // pointer, remaining-read counter and read pipeline valid
    always_comb
    begin
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        pipe_vld_next = pipe_vld_reg;
        if (cmd.clear)
        begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
        end
        else if (cmd.load)
        begin
            pipe_vld_next = 1'b0;
            cnt_next      = '0;
            pos_next      = idx_x[AW-1:0];
            if (func == fds_pkg::FUNC_FIND_NAME)
            begin
                if (idx_ok && !packed_name.bad)
                    cnt_next = CNTW'(ENTRIES_X - idx_x);
            end
            else if (func == fds_pkg::FUNC_FIND_TYPE)
            begin
                cnt_next = FULL_CNT;
                if (backward)
                begin
                    if (idx_x == '0 || idx_x > ENTRIES_X)
                        pos_next = LAST_POS;
                    else
                        pos_next = AW'(idx_x - 1'b1);
                end
                else
                begin
                    if (idx_x + 1'b1 >= ENTRIES_X)
                        pos_next = '0;
                    else
                        pos_next = AW'(idx_x + 1'b1);
                end
            end
        end
        else if (cmd.scan)
        begin
            pipe_vld_next = issue;
            if (issue)
            begin
                pos_next = step_pos;
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            cnt_reg      <= '0;
            pipe_vld_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
            pipe_vld_reg <= pipe_vld_next;
        end
    end

    // entry memory: one write port (clearing pass or entry write), one read port
    assign mem_we    = cmd.clear
                    || (cmd.load && func == fds_pkg::FUNC_WRITE && idx_ok);
    assign mem_waddr = cmd.clear ? pos_reg : idx_x[AW-1:0];
    assign mem_wdata = cmd.clear ? {{(2*HW){1'b0}}, fds_pkg::NO_TYPE}
                                 : {entry_first, entry_second, type_id};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (issue)
            rd_data_reg <= mem[pos_reg];
    end

    assign hit_x = XW'(pipe_pos_reg);

    always_ff @(posedge clk)
    begin
        if (issue)
            pipe_pos_reg <= pos_reg;
        if (cmd.load)
        begin
            by_name_reg <= (func == fds_pkg::FUNC_FIND_NAME);
            back_reg    <= (func == fds_pkg::FUNC_FIND_TYPE) && backward;
            type_reg    <= type_id;
            first_reg   <= packed_name.first;
            second_reg  <= packed_name.second;
        end
        if (cmd.res_load)
        begin
            res_found_reg <= hit;
            res_index_reg <= hit ? hit_x[fds_pkg::IDX_W-1:0] : '0;
        end
        if (cmd.out_load)
        begin
            out_found_reg <= res_found_reg;
            out_index_reg <= res_index_reg;
        end
    end

    assign sts.clear_last = (pos_reg == LAST_POS);
    assign sts.scan_done  = hit || (!pipe_vld_reg && cnt_reg == '0);

    assign found       = out_found_reg;
    assign entry_index = out_index_reg;

endmodule

`default_nettype wire

[rtl/core/file_directory_search.sv]
// Top level of the directory search block: joins the controller and the
// datapath to the item channels. Depends on fds_pkg, fds_in_if, fds_out_if,
// fds_ctrl and fds_datapath.
//
// Use:
//   in_ch  carries one request item: func selects entry write, find by name
//          or find by type; index is the entry to write or the scan start.
//   out_ch carries exactly one result item per request: found and
//          entry_index (both zero for writes, unused codes and misses).
//   Both channels transfer an item on a clock edge with valid and ready high.
// Reset: after rst_n rises the entry memory is swept once, one entry per
//   cycle, to empty names of type fifteen; in_ch.ready stays low until the
//   sweep is done.
// Throughput: one item is worked on at a time. The scan reads
//   one entry per cycle through the single memory read port and ends at
//   the first hit or when its reads run out. A find-by-type miss reads
//   all ENTRIES entries, a find-by-name at most ENTRIES - index. Writes,
//   unused codes and names that cannot match produce their result without
//   reading an entry. in_ch.ready rises in the cycle in which the result
//   enters the output register.
// Stalls: the result sits in an output register; a new request is accepted
//   while it waits, and that request's result is held back until out_ch
//   takes the earlier one.
`default_nettype none

module file_directory_search #(
    parameter int ENTRIES = fds_pkg::ENTRIES_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fds_in_if.sink     in_ch,
    fds_out_if.source  out_ch
);

    fds_pkg::cmd_t cmd;
    fds_pkg::sts_t sts;

    fds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    fds_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .func         (in_ch.func),
        .index        (in_ch.index),
        .name_bytes   (in_ch.name_bytes),
        .type_id      (in_ch.type_id),
        .backward     (in_ch.backward),
        .entry_first  (in_ch.entry_first),
        .entry_second (in_ch.entry_second),
        .cmd          (cmd),
        .sts          (sts),
        .found        (out_ch.found),
        .entry_index  (out_ch.entry_index)
    );

endmodule

`default_nettype wire

[rtl/core/fds_checker.sv]
// Port-level checks for the directory search block, bound to the top level.
// Depends on fds_pkg.
`default_nettype none

module fds_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic                       found,
    input wire logic [fds_pkg::IDX_W-1:0]  entry_index
);

    // one request in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted back to back");

    // a result is loaded only while no request can be accepted
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while input was ready");

    // a miss always reports index zero
    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (entry_index == '0))
        else $error("miss with non-zero index");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(found) && $stable(entry_index)))
        else $error("stalled result changed");

endmodule

bind file_directory_search fds_checker u_fds_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .found       (out_ch.found),
    .entry_index (out_ch.entry_index)
);

`default_nettype wire

[tb/file_directory_search_test.sv]
// Self-checking testbench for the directory search block: a directed table of
// requests, then random write / search traffic under several idling modes.
// Depends on fds_pkg, fds_in_if, fds_out_if and file_directory_search.
`default_nettype none

module file_directory_search_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_ENTRIES = fds_pkg::ENTRIES_DEFAULT;

    // func code that the block must treat as a no-op
    localparam logic [fds_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 272;
    localparam int PHASE_ITEMS  = 68;
    localparam int KNOWN_DEPTH  = 32;
    localparam int DRAIN_CYCLES = 64;

    // One request item as it travels on in_ch.
    typedef struct packed {
        logic [fds_pkg::FUNC_W-1:0] func;
        logic [fds_pkg::IDX_W-1:0]  index;
        logic [fds_pkg::NAME_W-1:0] name_bytes;
        logic [fds_pkg::TYPE_W-1:0] type_id;
        logic                       backward;
        logic [fds_pkg::HALF_W-1:0] entry_first;
        logic [fds_pkg::HALF_W-1:0] entry_second;
    } dir_req_t;

    // One result item as it travels on out_ch.
    typedef struct packed {
        logic                      found;
        logic [fds_pkg::IDX_W-1:0] entry_index;
    } dir_result_t;

    // Row of the directed table; typed rows carry their answer by hand.
    typedef struct {
        dir_req_t    req;
        bit          typed;
        dir_result_t answer;
    } directed_row_t;

    // Name written by a well-formed write, kept so that later searches hit it.
    typedef struct {
        logic [fds_pkg::NAME_W-1:0] bytes;
        logic [fds_pkg::TYPE_W-1:0] type_id;
        int                         index;
    } known_name_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic clk;
    logic rst_n;

    fds_in_if  in_ch ();
    fds_out_if out_ch ();

    file_directory_search #(
        .ENTRIES (DIR_ENTRIES)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow copy of the entry store
    logic [fds_pkg::HALF_W-1:0] shadow_first  [DIR_ENTRIES];
    logic [fds_pkg::HALF_W-1:0] shadow_second [DIR_ENTRIES];
    logic [fds_pkg::TYPE_W-1:0] shadow_type   [DIR_ENTRIES];

    dir_result_t   pending_answers [$];
    directed_row_t directed_rows [$];
    known_name_t   known_names [$];
    idle_mode_t    idle_mode;
    int            error_count;

    // ------------------------------------------------------------------
    // Clock: 8 ns period
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Generous wall: a few times the slowest legal run (every search a full
    // sweep, plus the clearing pass after reset).
    initial
    begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Packs up to eight bytes into two 32-bit accumulators, returned as
    // {second, first}. Packing stops at a NUL or a dot. Anything landing
    // above bit 23 of a half makes that name unmatchable - this covers
    // control bytes (which wrap negative after the bias) and wide codes
    // in the top position of a half.
    function automatic logic [63:0] pack_name(input logic [fds_pkg::NAME_W-1:0] bytes);
        logic [31:0] acc [2];
        logic [31:0] ch;
        bit          stopped;
        acc[0]  = '0;
        acc[1]  = '0;
        stopped = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            ch = {24'd0, bytes[8*i +: 8]};
            if (ch[7:0] == fds_pkg::CHAR_NUL || ch[7:0] == fds_pkg::CHAR_DOT)
                stopped = 1'b1;
            if (!stopped)
                acc[i / 4] = acc[i / 4]
                    | ((ch - {24'd0, fds_pkg::CHAR_BIAS}) << (fds_pkg::CHAR_SHIFT * (i % 4)));
        end
        return {acc[1], acc[0]};
    endfunction

    // Works out the result of one accepted request and applies any write to
    // the shadow store.
    function automatic dir_result_t directory_answer(input dir_req_t r);
        dir_result_t a;
        logic [63:0] packed_name;
        int          pos;
        bit          hit;
        a   = '0;
        hit = 1'b0;
        case (r.func)
            fds_pkg::FUNC_WRITE:
            begin
                shadow_first[r.index]  = r.entry_first;
                shadow_second[r.index] = r.entry_second;
                shadow_type[r.index]   = r.type_id;
            end
            fds_pkg::FUNC_FIND_NAME:
            begin
                packed_name = pack_name(r.name_bytes);
                if (packed_name[63:56] == 8'd0 && packed_name[31:24] == 8'd0)
                begin
                    for (pos = int'(r.index); pos < DIR_ENTRIES && !hit; pos++)
                    begin
                        if (shadow_first[pos] == packed_name[23:0] &&
                            shadow_second[pos] == packed_name[55:32] &&
                            shadow_type[pos] == r.type_id)
                        begin
                            hit           = 1'b1;
                            a.found       = 1'b1;
                            a.entry_index = fds_pkg::IDX_W'(pos);
                        end
                    end
                end
            end
            fds_pkg::FUNC_FIND_TYPE:
            begin
                // starts one step away from index; index itself comes last
                pos = r.backward ? int'(r.index) - 1 : int'(r.index) + 1;
                for (int n = 0; n < DIR_ENTRIES && !hit; n++)
                begin
                    if (pos < 0 || pos >= DIR_ENTRIES)
                        pos = r.backward ? DIR_ENTRIES - 1 : 0;
                    if (shadow_type[pos] == r.type_id)
                    begin
                        hit           = 1'b1;
                        a.found       = 1'b1;
                        a.entry_index = fds_pkg::IDX_W'(pos);
                    end
                    pos = r.backward ? pos - 1 : pos + 1;
                end
            end
            default:
            begin
                // unused code: no change, zero result
            end
        endcase
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_row(input logic [fds_pkg::FUNC_W-1:0] func, input int index,
                           input logic [fds_pkg::NAME_W-1:0] bytes,
                           input logic [fds_pkg::TYPE_W-1:0] type_id,
                           input logic backward, input logic [fds_pkg::HALF_W-1:0] first,
                           input logic [fds_pkg::HALF_W-1:0] second, input bit typed,
                           input logic found, input int entry_index);
        directed_row_t row;
        row.req.func         = func;
        row.req.index        = fds_pkg::IDX_W'(index);
        row.req.name_bytes   = bytes;
        row.req.type_id      = type_id;
        row.req.backward     = backward;
        row.req.entry_first  = first;
        row.req.entry_second = second;
        row.typed            = typed;
        row.answer.found       = found;
        row.answer.entry_index = fds_pkg::IDX_W'(entry_index);
        directed_rows.push_back(row);
    endtask

    // Write whose halves are the packed form of a name; a write always
    // answers zero.
    task automatic add_named_write(input int index, input logic [fds_pkg::NAME_W-1:0] bytes,
                                   input logic [fds_pkg::TYPE_W-1:0] type_id);
        logic [63:0] pk;
        pk = pack_name(bytes);
        add_row(fds_pkg::FUNC_WRITE, index, bytes, type_id, 1'b0, pk[23:0], pk[55:32],
                1'b1, 1'b0, 0);
    endtask

    // Printable-range name of random length, closed by NUL or dot when shorter
    // than eight bytes, with junk after the terminator that must be ignored.
    function automatic logic [fds_pkg::NAME_W-1:0] random_name();
        logic [fds_pkg::NAME_W-1:0] b;
        int                         len;
        b   = {$urandom, $urandom};
        len = $urandom_range(0, 8);
        for (int i = 0; i < 8; i++)
        begin
            if (i < len)
                b[8*i +: 8] = 8'($urandom_range(32'h20, 32'h5F));
        end
        if (len < 8)
            b[8*len +: 8] = $urandom_range(0, 1) ? fds_pkg::CHAR_NUL : fds_pkg::CHAR_DOT;
        return b;
    endfunction

    // Mostly well-formed traffic: named writes, then searches aimed at what
    // was written. The rest is raw writes, junk names and the unused code.
    function automatic dir_req_t random_item();
        dir_req_t    r;
        known_name_t k;
        logic [63:0] pk;
        int          pick;
        r.func         = FUNC_UNUSED;
        r.index        = fds_pkg::IDX_W'($urandom);
        r.name_bytes   = {$urandom, $urandom};
        r.type_id      = fds_pkg::TYPE_W'($urandom);
        r.backward     = 1'($urandom);
        r.entry_first  = fds_pkg::HALF_W'($urandom);
        r.entry_second = fds_pkg::HALF_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            r.func         = fds_pkg::FUNC_WRITE;
            r.name_bytes   = random_name();
            pk             = pack_name(r.name_bytes);
            r.entry_first  = pk[23:0];
            r.entry_second = pk[55:32];
            k.bytes   = r.name_bytes;
            k.type_id = r.type_id;
            k.index   = int'(r.index);
            known_names.push_back(k);
            if (known_names.size() > KNOWN_DEPTH)
                void'(known_names.pop_front());
        end
        else if (pick < 55 && known_names.size() > 0)
        begin
            k          = known_names[$urandom_range(0, known_names.size() - 1)];
            r.func     = fds_pkg::FUNC_FIND_NAME;
            r.name_bytes = k.bytes;
            if ($urandom_range(0, 9) != 0)
                r.type_id = k.type_id;
            // usually start at or below the entry so the scan reaches it
            if ($urandom_range(0, 4) != 0)
                r.index = fds_pkg::IDX_W'($urandom_range(0, k.index));
        end
        else if (pick < 80)
        begin
            r.func = fds_pkg::FUNC_FIND_TYPE;
            if (known_names.size() > 0 && $urandom_range(0, 9) < 7)
                r.type_id = known_names[$urandom_range(0, known_names.size() - 1)].type_id;
        end
        else if (pick < 90)
            r.func = fds_pkg::FUNC_WRITE;
        else if (pick < 96)
            r.func = fds_pkg::FUNC_FIND_NAME;
        return r;
    endfunction

    function automatic bit sender_idle();
        if (idle_mode == IDLE_SENDER)
            return $urandom_range(0, 99) < 60;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 22;
        return 1'b0;
    endfunction

    function automatic bit receiver_stall();
        if (idle_mode == IDLE_RECEIVER)
            return $urandom_range(0, 99) < 60;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 22;
        return 1'b0;
    endfunction

    // Presents one item from a falling edge, holds it until accepted, and
    // logs its expected result. Returns at the falling edge after acceptance,
    // so valid is assigned once per step.
    task automatic send_item(input dir_req_t r, input bit typed, input dir_result_t answer);
        dir_result_t predicted;
        while (sender_idle())
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.func         <= r.func;
        in_ch.index        <= r.index;
        in_ch.name_bytes   <= r.name_bytes;
        in_ch.type_id      <= r.type_id;
        in_ch.backward     <= r.backward;
        in_ch.entry_first  <= r.entry_first;
        in_ch.entry_second <= r.entry_second;
        in_ch.valid        <= 1'b1;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        // shadow store must advance even when the answer is typed in
        predicted = directory_answer(r);
        pending_answers.push_back(typed ? answer : predicted);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, checked at the rising edge
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ch.ready <= !receiver_stall();

    always @(posedge clk)
    begin
        dir_result_t exp_res;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result item with nothing outstanding: found %0d, entry_index %0d",
                       out_ch.found, out_ch.entry_index);
                error_count++;
            end
            else
            begin
                exp_res = pending_answers.pop_front();
                if (out_ch.found !== exp_res.found)
                begin
                    $error("found: expected %0d, got %0d", exp_res.found, out_ch.found);
                    error_count++;
                end
                if (out_ch.entry_index !== exp_res.entry_index)
                begin
                    $error("entry_index: expected %0d, got %0d",
                           exp_res.entry_index, out_ch.entry_index);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        directed_row_t row;
        dir_result_t   no_answer;

        no_answer   = '0;
        error_count = 0;
        idle_mode   = IDLE_NONE;

        // inputs known from time zero
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.func         = fds_pkg::FUNC_WRITE;
        in_ch.index        = '0;
        in_ch.name_bytes   = '0;
        in_ch.type_id      = '0;
        in_ch.backward     = 1'b0;
        in_ch.entry_first  = '0;
        in_ch.entry_second = '0;
        out_ch.ready       = 1'b0;

        // store after reset: empty names, no type
        for (int i = 0; i < DIR_ENTRIES; i++)
        begin
            shadow_first[i]  = '0;
            shadow_second[i] = '0;
            shadow_type[i]   = fds_pkg::NO_TYPE;
        end

        // Directed table. Columns: func, index, name bytes, type, backward,
        // first half, second half, typed answer?, found, entry_index.
        // Fresh store: type search for "none" hits the neighbour, with wrap
        // both ways at the ends of the store
        add_row(fds_pkg::FUNC_FIND_TYPE, 0,    64'h0, fds_pkg::NO_TYPE, 1'b0, '0, '0,
                1'b1, 1'b1, 1);
        add_row(fds_pkg::FUNC_FIND_TYPE, 0,    64'h0, fds_pkg::NO_TYPE, 1'b1, '0, '0,
                1'b1, 1'b1, 2047);
        add_row(fds_pkg::FUNC_FIND_TYPE, 2047, 64'h0, fds_pkg::NO_TYPE, 1'b0, '0, '0,
                1'b1, 1'b1, 0);
        // type nobody has: full sweep, miss
        add_row(fds_pkg::FUNC_FIND_TYPE, 5,    64'h0, 4'd3,    1'b0, '0, '0, 1'b1, 1'b0, 0);
        // empty name of no type matches every untouched entry
        add_row(fds_pkg::FUNC_FIND_NAME, 2047, 64'h0, fds_pkg::NO_TYPE, 1'b0, '0, '0,
                1'b1, 1'b1, 2047);
        add_row(fds_pkg::FUNC_FIND_NAME, 0,    64'h0, 4'd4,    1'b0, '0, '0, 1'b1, 1'b0, 0);
        // unused code with busy fields: ignored
        add_row(FUNC_UNUSED, 1234, '1, 4'd7, 1'b1, '1, '1, 1'b1, 1'b0, 0);
        // writes at both ends, halves at their extremes
        add_row(fds_pkg::FUNC_WRITE, 0,    64'h0, 4'd0, 1'b0, '1, '1, 1'b1, 1'b0, 0);
        add_row(fds_pkg::FUNC_WRITE, 2047, '1,    4'd3, 1'b1, '0, '0, 1'b1, 1'b0, 0);
        add_row(fds_pkg::FUNC_FIND_TYPE, 1,    64'h0, 4'd0, 1'b1, '0, '0, 1'b1, 1'b1, 0);
        add_row(fds_pkg::FUNC_FIND_TYPE, 2046, 64'h0, 4'd3, 1'b0, '0, '0, 1'b1, 1'b1, 2047);
        // only match is the start itself, reached last after the wrap
        add_row(fds_pkg::FUNC_FIND_TYPE, 2047, 64'h0, 4'd3, 1'b0, '0, '0, 1'b0, 1'b0, 0);
        add_row(fds_pkg::FUNC_FIND_TYPE, 0,    64'h0, 4'd0, 1'b1, '0, '0, 1'b0, 1'b0, 0);
        // full eight-character name, then hit, start past it, wrong type
        add_named_write(100, 64'h4847_4645_4443_4241, 4'd5);
        add_row(fds_pkg::FUNC_FIND_NAME, 0,   64'h4847_4645_4443_4241, 4'd5, 1'b0, '0, '0,
                1'b1, 1'b1, 100);
        add_row(fds_pkg::FUNC_FIND_NAME, 101, 64'h4847_4645_4443_4241, 4'd5, 1'b0, '0, '0,
                1'b1, 1'b0, 0);
        add_row(fds_pkg::FUNC_FIND_NAME, 100, 64'h4847_4645_4443_4241, 4'd6, 1'b0, '0, '0,
                1'b1, 1'b0, 0);
        // short name; dot and NUL both end it, trailing bytes ignored
        add_named_write(1500, 64'h0000_0000_0000_4241, 4'd2);
        add_row(fds_pkg::FUNC_FIND_NAME, 7, 64'h0000_5A59_582E_4241, 4'd2, 1'b0, '0, '0,
                1'b0, 1'b0, 0);
        add_row(fds_pkg::FUNC_FIND_NAME, 7, 64'h0000_0000_5100_4241, 4'd2, 1'b0, '0, '0,
                1'b0, 1'b0, 0);
        // control byte wraps below the bias: never matches
        add_row(fds_pkg::FUNC_FIND_NAME, 0, 64'h0000_0000_0000_001F, fds_pkg::NO_TYPE,
                1'b0, '0, '0, 1'b1, 1'b0, 0);
        // wide code in the top slot of a half spills past 24 bits
        add_row(fds_pkg::FUNC_FIND_NAME, 0, 64'h0000_0000_7F20_2020, fds_pkg::NO_TYPE,
                1'b0, '0, '0, 1'b1, 1'b0, 0);
        add_row(fds_pkg::FUNC_FIND_NAME, 0, '1, fds_pkg::NO_TYPE, 1'b0, '0, '0,
                1'b1, 1'b0, 0);
        // high bytes in the lower slots still fit
        add_named_write(301, 64'h0000_0000_00FF_7F60, 4'd9);
        add_row(fds_pkg::FUNC_FIND_NAME, 300, 64'h0000_0000_00FF_7F60, 4'd9, 1'b0, '0, '0,
                1'b0, 1'b0, 0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // in_ch.ready stays low through the clearing pass; the first
        // handshake simply waits for it
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_item(row.req, row.typed, row.answer);
        end

        // random part, one idling mode per quarter
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            case (k / PHASE_ITEMS)
                0:       idle_mode = IDLE_NONE;
                1:       idle_mode = IDLE_SENDER;
                2:       idle_mode = IDLE_RECEIVER;
                default: idle_mode = IDLE_BOTH;
            endcase
            send_item(random_item(), 1'b0, no_answer);
        end
        in_ch.valid <= 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        // catch any stray result item after the last one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
